### src/dhcp_client_lease_fsm_assert.svh
// Assertion macros for the DHCP client lease block.
`ifndef DHCP_CLIENT_LEASE_FSM_ASSERT_SVH
`define DHCP_CLIENT_LEASE_FSM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define DCL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/dcl_pkg.sv
// Types and constants shared by the DHCP client lease block.
package dcl_pkg;

   typedef enum logic [2:0] {
      ST_INIT    = 3'd0,
      ST_SELECT  = 3'd1,
      ST_REQUEST = 3'd2,
      ST_BOUND   = 3'd3,
      ST_RENEW   = 3'd4,
      ST_REBIND  = 3'd5
   } state_type;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_TIMER = 2'd1,
      CMD_REPLY = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      SEND_NONE     = 2'd0,
      SEND_DISCOVER = 2'd1,
      SEND_REQUEST  = 2'd2
   } send_type;

   typedef enum logic [2:0] {
      VERDICT_NONE       = 3'd0,
      VERDICT_HANDLED    = 3'd1,
      VERDICT_NO_TYPE    = 3'd2,
      VERDICT_NOT_OFFER  = 3'd3,
      VERDICT_NOT_ACK    = 3'd4,
      VERDICT_UNEXPECTED = 3'd5
   } verdict_type;

   typedef enum logic [0:0] {
      CSR_DISCOVER_TIMEOUT = 1'b0,
      CSR_REQUEST_TIMEOUT  = 1'b1
   } csr_index_type;

   localparam logic [7:0]  MT_OFFER           = 8'd2;
   localparam logic [7:0]  MT_ACK             = 8'd5;
   localparam logic [8:0]  SMALL_FRAME        = 9'd309;
   localparam logic [8:0]  LARGE_FRAME        = 9'd321;
   localparam int unsigned USEC_WIDTH         = 20;
   localparam logic [USEC_WIDTH-1:0] USEC_PER_SEC = USEC_WIDTH'(1000 * 1000);
   localparam logic [31:0] TIMEOUT_RESET      = 32'd10000000;

   typedef struct packed {
      cmd_type     cmd;
      logic        domain_present;
      logic        has_msg_code;
      logic [7:0]  msg_code;
      logic [31:0] offered_addr;
      logic [31:0] server_id;
      logic [31:0] lease_seconds;
   } req_type;

   typedef struct packed {
      send_type    send_kind;
      logic [31:0] client_addr;
      logic [31:0] server_addr;
      logic [31:0] wanted_addr;
      logic        add_request_options;
      logic [8:0]  frame_bytes;
      logic        arm_timer;
      logic [31:0] timeout_us;
      verdict_type verdict;
      logic        discard_address;
      logic        apply_ack;
      state_type   state_now;
   } rsp_type;

endpackage

### src/dcl_retry.sv
// Re-request timeout: lease halved or quartered, clamped, scaled to microseconds.
module dcl_retry #(
   parameter int unsigned MAX_RETRY_SECONDS = 3600
) (
   input  logic [31:0] lease,
   input  logic        shift_two,
   output logic [31:0] timeout_us
);

   localparam int unsigned SecWidth  = $clog2(MAX_RETRY_SECONDS + 1);
   localparam int unsigned ProdWidth = SecWidth + dcl_pkg::USEC_WIDTH;
   localparam logic [31:0] MaxSec    = 32'(MAX_RETRY_SECONDS);

   logic [31:0]          sec_full;
   logic [SecWidth-1:0]  sec;
   logic [ProdWidth-1:0] prod;

   always_comb begin
      sec_full   = shift_two ? (lease >> 2) : (lease >> 1);
      sec        = (sec_full > MaxSec) ? SecWidth'(MaxSec) : SecWidth'(sec_full);
      prod       = ProdWidth'(sec) * ProdWidth'(dcl_pkg::USEC_PER_SEC);
      timeout_us = 32'(prod);
   end

endmodule

### src/dcl_decide.sv
// Lease state registers and the per-event decision logic.
module dcl_decide #(
   parameter int unsigned MAX_RETRY_SECONDS = 3600
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  dcl_pkg::req_type req,
   input  logic [31:0]      discover_timeout_us,
   input  logic [31:0]      request_timeout_us,
   output dcl_pkg::rsp_type rsp
);

   dcl_pkg::state_type state_ff, state_in;
   logic [31:0]        lease_ff, lease_in;
   logic [31:0]        addr_ff, addr_in;
   logic [31:0]        retry_lease;
   logic               retry_shift_two;
   logic [31:0]        retry_us;

   // ACK uses the fresh lease halved; renew/rebind use the stored lease quartered
   assign retry_lease     = (req.cmd == dcl_pkg::CMD_REPLY) ? req.lease_seconds : lease_ff;
   assign retry_shift_two = (req.cmd != dcl_pkg::CMD_REPLY);

   dcl_retry #(
      .MAX_RETRY_SECONDS(MAX_RETRY_SECONDS)
   ) u_retry (
      .lease     (retry_lease),
      .shift_two (retry_shift_two),
      .timeout_us(retry_us)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcl_pkg::ST_INIT;
         lease_ff <= '0;
         addr_ff  <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         lease_ff <= lease_in;
         addr_ff  <= addr_in;
      end
   end

   always_comb begin
      rsp      = '0;
      state_in = state_ff;
      lease_in = lease_ff;
      addr_in  = addr_ff;
      case (req.cmd)
         dcl_pkg::CMD_START: begin
            state_in        = dcl_pkg::ST_SELECT;
            rsp.send_kind   = dcl_pkg::SEND_DISCOVER;
            rsp.frame_bytes = dcl_pkg::SMALL_FRAME;
            rsp.arm_timer   = 1'b1;
            rsp.timeout_us  = discover_timeout_us;
         end
         dcl_pkg::CMD_TIMER: begin
            if (req.domain_present) begin
               if (state_ff inside {dcl_pkg::ST_BOUND, dcl_pkg::ST_RENEW}) begin
                  state_in = (state_ff == dcl_pkg::ST_BOUND) ? dcl_pkg::ST_RENEW
                                                              : dcl_pkg::ST_REBIND;
                  rsp.send_kind   = dcl_pkg::SEND_REQUEST;
                  rsp.client_addr = addr_ff;
                  rsp.wanted_addr = addr_ff;
                  rsp.frame_bytes = dcl_pkg::SMALL_FRAME;
                  rsp.arm_timer   = 1'b1;
                  rsp.timeout_us  = retry_us;
               end else begin
                  // rebind expiry drops the address before rediscovery
                  if (state_ff == dcl_pkg::ST_REBIND) begin
                     rsp.discard_address = 1'b1;
                     addr_in             = '0;
                  end
                  state_in        = dcl_pkg::ST_SELECT;
                  rsp.send_kind   = dcl_pkg::SEND_DISCOVER;
                  rsp.frame_bytes = dcl_pkg::SMALL_FRAME;
                  rsp.arm_timer   = 1'b1;
                  rsp.timeout_us  = discover_timeout_us;
               end
            end
         end
         dcl_pkg::CMD_REPLY: begin
            if (!req.has_msg_code) begin
               rsp.verdict = dcl_pkg::VERDICT_NO_TYPE;
            end else if (state_ff == dcl_pkg::ST_SELECT) begin
               if (req.msg_code != dcl_pkg::MT_OFFER) begin
                  rsp.verdict = dcl_pkg::VERDICT_NOT_OFFER;
               end else begin
                  state_in                = dcl_pkg::ST_REQUEST;
                  rsp.send_kind           = dcl_pkg::SEND_REQUEST;
                  rsp.server_addr         = req.server_id;
                  rsp.wanted_addr         = req.offered_addr;
                  rsp.add_request_options = 1'b1;
                  rsp.frame_bytes         = dcl_pkg::LARGE_FRAME;
                  rsp.arm_timer           = 1'b1;
                  rsp.timeout_us          = request_timeout_us;
                  rsp.verdict             = dcl_pkg::VERDICT_HANDLED;
               end
            end else if (state_ff inside {dcl_pkg::ST_REQUEST, dcl_pkg::ST_RENEW,
                                          dcl_pkg::ST_REBIND}) begin
               if (req.msg_code != dcl_pkg::MT_ACK) begin
                  rsp.verdict = dcl_pkg::VERDICT_NOT_ACK;
               end else begin
                  lease_in       = req.lease_seconds;
                  addr_in        = req.offered_addr;
                  state_in       = dcl_pkg::ST_BOUND;
                  rsp.arm_timer  = 1'b1;
                  rsp.timeout_us = retry_us;
                  rsp.verdict    = dcl_pkg::VERDICT_HANDLED;
                  rsp.apply_ack  = 1'b1;
               end
            end else begin
               rsp.verdict = dcl_pkg::VERDICT_UNEXPECTED;
            end
         end
         default: ;
      endcase
      rsp.state_now = state_in;
   end

endmodule

### src/dhcp_client_lease_fsm.sv
// Top level of the DHCP client lease block: channels, registers, decision stage.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tuser event kind, tdata reply fields
//  rsp_     out  rsp_tvalid/rsp_tready  tuser send kind, tdata decision fields
//  csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle sustained while rsp_tready is high; an accepted item passes the input
// register, then decision logic and the lease multiplier into the result register.
// Reset is synchronous: state init, lease and address zero, both timeouts 10 s.
// A stalled result holds the result register; the input register still takes one
// more item, and the input stalls only when both registers are full.
// Configuration writes are always ready and are written straight into the timeout registers.
`include "dhcp_client_lease_fsm_assert.svh"

module dhcp_client_lease_fsm #(
   parameter int unsigned MAX_RETRY_SECONDS = 3600
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // cmd
   // domain_present, has_msg_code, msg_code, offered_addr, server_id, lease_seconds
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,  // send_kind
   // client_addr, server_addr, wanted_addr, add_request_options, frame_bytes,
   // arm_timer, timeout_us, verdict, discard_address, apply_ack, state_now
   output logic [151:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_data
);

   dcl_pkg::req_type req_in, req_ff;
   dcl_pkg::rsp_type dec_rsp, rsp_ff;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic [31:0]      disc_to_ff, disc_to_in;
   logic [31:0]      req_to_ff, req_to_in;

   assign req_in.cmd            = dcl_pkg::cmd_type'(req_tuser);
   assign req_in.domain_present = req_tdata[0];
   assign req_in.has_msg_code   = req_tdata[1];
   assign req_in.msg_code       = req_tdata[9:2];
   assign req_in.offered_addr   = req_tdata[41:10];
   assign req_in.server_id      = req_tdata[73:42];
   assign req_in.lease_seconds  = req_tdata[105:74];

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   assign csr_ready  = 1'b1;
   assign disc_to_in = (csr_valid && csr_index == dcl_pkg::CSR_DISCOVER_TIMEOUT)
                       ? csr_data : disc_to_ff;
   assign req_to_in  = (csr_valid && csr_index == dcl_pkg::CSR_REQUEST_TIMEOUT)
                       ? csr_data : req_to_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         disc_to_ff   <= dcl_pkg::TIMEOUT_RESET;
         req_to_ff    <= dcl_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         disc_to_ff   <= disc_to_in;
         req_to_ff    <= req_to_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= dec_rsp;
      end
   end

   dcl_decide #(
      .MAX_RETRY_SECONDS(MAX_RETRY_SECONDS)
   ) u_decide (
      .clock              (clock),
      .reset              (reset),
      .step_en            (advance),
      .req                (req_ff),
      .discover_timeout_us(disc_to_ff),
      .request_timeout_us (req_to_ff),
      .rsp                (dec_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = rsp_ff.send_kind;
   assign rsp_tdata  = {5'd0,
                        rsp_ff.state_now,
                        rsp_ff.apply_ack,
                        rsp_ff.discard_address,
                        rsp_ff.verdict,
                        rsp_ff.timeout_us,
                        rsp_ff.arm_timer,
                        rsp_ff.frame_bytes,
                        rsp_ff.add_request_options,
                        rsp_ff.wanted_addr,
                        rsp_ff.server_addr,
                        rsp_ff.client_addr};

   `DCL_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   `DCL_ASSERT_NOW(a_no_send_no_frame, clock, reset,
      out_valid_ff && rsp_ff.send_kind == dcl_pkg::SEND_NONE, rsp_ff.frame_bytes == 9'd0)
   `DCL_ASSERT_NOW(a_ack_binds, clock, reset, out_valid_ff && rsp_ff.apply_ack,
      rsp_ff.state_now == dcl_pkg::ST_BOUND && rsp_ff.verdict == dcl_pkg::VERDICT_HANDLED)
   `DCL_ASSERT_NOW(a_discard_rediscovers, clock, reset, out_valid_ff && rsp_ff.discard_address,
      rsp_ff.send_kind == dcl_pkg::SEND_DISCOVER && rsp_ff.state_now == dcl_pkg::ST_SELECT)

endmodule

### dv/tb.sv
// Self-checking testbench for the DHCP client lease state machine.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned RETRY_CAP_S = 3600;
   localparam int unsigned USEC_PER_S  = 1000000;
   localparam int unsigned PHASE_ITEMS = 440;
   localparam int unsigned MAX_PRINTS  = 100;
   // command code with no meaning, ignored by the block
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;

   typedef struct {
      logic [1:0]  cmd;
      logic        dom;
      logic        has_type;
      logic [7:0]  mtype;
      logic [31:0] yiaddr;
      logic [31:0] sid;
      logic [31:0] lease;
   } dhcp_evt_type;

   typedef struct {
      dhcp_evt_type     ev;
      bit               typed;
      dcl_pkg::rsp_type want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;
   logic [151:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   // predictor state and register copies
   dcl_pkg::state_type fsm_state = dcl_pkg::ST_INIT;
   logic [31:0]        lease_secs = '0;
   logic [31:0]        bound_ip = '0;
   logic [31:0]        disc_tmo = dcl_pkg::TIMEOUT_RESET;
   logic [31:0]        req_tmo = dcl_pkg::TIMEOUT_RESET;

   dcl_pkg::rsp_type   pending_decisions[$];
   stim_row_type       stim_rows[$];
   int unsigned        errors = 0;
   bit                 calm = 1'b0;

   dhcp_client_lease_fsm #(
      .MAX_RETRY_SECONDS(RETRY_CAP_S)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 8);
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("%0t mismatch %s: got %h want %h", $time, field, got, want);
   endtask

   function automatic logic [31:0] retry_usec(input int shift);
      logic [31:0] secs;
      logic [63:0] usec;
      secs = lease_secs >> shift;
      if (secs > RETRY_CAP_S)
         secs = RETRY_CAP_S;
      usec = 64'(secs) * 64'(USEC_PER_S);
      return usec[31:0];
   endfunction

   task automatic send_discover(inout dcl_pkg::rsp_type r);
      fsm_state = dcl_pkg::ST_SELECT;
      r.send_kind = dcl_pkg::SEND_DISCOVER;
      r.frame_bytes = dcl_pkg::SMALL_FRAME;
      r.arm_timer = 1'b1;
      r.timeout_us = disc_tmo;
   endtask

   task automatic send_rerequest(input dcl_pkg::state_type nxt, inout dcl_pkg::rsp_type r);
      fsm_state = nxt;
      r.send_kind = dcl_pkg::SEND_REQUEST;
      r.client_addr = bound_ip;
      r.wanted_addr = bound_ip;
      r.frame_bytes = dcl_pkg::SMALL_FRAME;
      r.arm_timer = 1'b1;
      r.timeout_us = retry_usec(2);
   endtask

   task automatic decide_event(input dhcp_evt_type ev, output dcl_pkg::rsp_type r);
      r = '0;
      if (ev.cmd == dcl_pkg::CMD_START) begin
         send_discover(r);
      end else if (ev.cmd == dcl_pkg::CMD_TIMER) begin
         if (ev.dom) begin
            case (fsm_state)
               dcl_pkg::ST_BOUND: send_rerequest(dcl_pkg::ST_RENEW, r);
               dcl_pkg::ST_RENEW: send_rerequest(dcl_pkg::ST_REBIND, r);
               dcl_pkg::ST_REBIND: begin
                  r.discard_address = 1'b1;
                  bound_ip = '0;
                  send_discover(r);
               end
               default: send_discover(r);
            endcase
         end
      end else if (ev.cmd == dcl_pkg::CMD_REPLY) begin
         if (!ev.has_type) begin
            r.verdict = dcl_pkg::VERDICT_NO_TYPE;
         end else if (fsm_state == dcl_pkg::ST_SELECT) begin
            if (ev.mtype != dcl_pkg::MT_OFFER) begin
               r.verdict = dcl_pkg::VERDICT_NOT_OFFER;
            end else begin
               fsm_state = dcl_pkg::ST_REQUEST;
               r.send_kind = dcl_pkg::SEND_REQUEST;
               r.server_addr = ev.sid;
               r.wanted_addr = ev.yiaddr;
               r.add_request_options = 1'b1;
               r.frame_bytes = dcl_pkg::LARGE_FRAME;
               r.arm_timer = 1'b1;
               r.timeout_us = req_tmo;
               r.verdict = dcl_pkg::VERDICT_HANDLED;
            end
         end else if (fsm_state inside {dcl_pkg::ST_REQUEST, dcl_pkg::ST_RENEW,
                                        dcl_pkg::ST_REBIND}) begin
            if (ev.mtype != dcl_pkg::MT_ACK) begin
               r.verdict = dcl_pkg::VERDICT_NOT_ACK;
            end else begin
               lease_secs = ev.lease;
               bound_ip = ev.yiaddr;
               fsm_state = dcl_pkg::ST_BOUND;
               r.arm_timer = 1'b1;
               r.timeout_us = retry_usec(1);
               r.verdict = dcl_pkg::VERDICT_HANDLED;
               r.apply_ack = 1'b1;
            end
         end else begin
            r.verdict = dcl_pkg::VERDICT_UNEXPECTED;
         end
      end
      r.state_now = fsm_state;
   endtask

   task automatic check_rsp(input dcl_pkg::rsp_type got, input dcl_pkg::rsp_type want);
      if (got.send_kind !== want.send_kind)
         report_mismatch("send_kind", got.send_kind, want.send_kind);
      if (got.client_addr !== want.client_addr)
         report_mismatch("client_addr", got.client_addr, want.client_addr);
      if (got.server_addr !== want.server_addr)
         report_mismatch("server_addr", got.server_addr, want.server_addr);
      if (got.wanted_addr !== want.wanted_addr)
         report_mismatch("wanted_addr", got.wanted_addr, want.wanted_addr);
      if (got.add_request_options !== want.add_request_options)
         report_mismatch("add_request_options", got.add_request_options,
                         want.add_request_options);
      if (got.frame_bytes !== want.frame_bytes)
         report_mismatch("frame_bytes", got.frame_bytes, want.frame_bytes);
      if (got.arm_timer !== want.arm_timer)
         report_mismatch("arm_timer", got.arm_timer, want.arm_timer);
      if (got.timeout_us !== want.timeout_us)
         report_mismatch("timeout_us", got.timeout_us, want.timeout_us);
      if (got.verdict !== want.verdict)
         report_mismatch("verdict", got.verdict, want.verdict);
      if (got.discard_address !== want.discard_address)
         report_mismatch("discard_address", got.discard_address, want.discard_address);
      if (got.apply_ack !== want.apply_ack)
         report_mismatch("apply_ack", got.apply_ack, want.apply_ack);
      if (got.state_now !== want.state_now)
         report_mismatch("state_now", got.state_now, want.state_now);
   endtask

   // valid and ready only move at rising edges, so the falling edge sees
   // exactly what the next rising edge will take
   always @(negedge clock) begin : rsp_monitor
      dcl_pkg::rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.send_kind = dcl_pkg::send_type'(rsp_tuser);
         got.client_addr = rsp_tdata[31:0];
         got.server_addr = rsp_tdata[63:32];
         got.wanted_addr = rsp_tdata[95:64];
         got.add_request_options = rsp_tdata[96];
         got.frame_bytes = rsp_tdata[105:97];
         got.arm_timer = rsp_tdata[106];
         got.timeout_us = rsp_tdata[138:107];
         got.verdict = dcl_pkg::verdict_type'(rsp_tdata[141:139]);
         got.discard_address = rsp_tdata[142];
         got.apply_ack = rsp_tdata[143];
         got.state_now = dcl_pkg::state_type'(rsp_tdata[146:144]);
         if (pending_decisions.size() == 0)
            report_mismatch("result with no item pending", got.state_now, '0);
         else
            check_rsp(got, pending_decisions.pop_front());
      end
   end

   task automatic feed_event(input dhcp_evt_type ev, input bit typed,
                             input dcl_pkg::rsp_type want);
      dcl_pkg::rsp_type pred;
      if (!calm && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= ev.cmd;
      req_tdata <= {6'b0, ev.lease, ev.sid, ev.yiaddr, ev.mtype, ev.has_type, ev.dom};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      decide_event(ev, pred);
      pending_decisions.push_back(typed ? want : pred);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_decisions.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input dcl_pkg::csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      if (idx == dcl_pkg::CSR_DISCOVER_TIMEOUT)
         disc_tmo = val;
      else
         req_tmo = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic dhcp_evt_type mk_event(input logic [1:0] cmd, input logic dom,
                                             input logic has_type, input logic [7:0] mtype,
                                             input logic [31:0] yiaddr,
                                             input logic [31:0] sid,
                                             input logic [31:0] lease);
      dhcp_evt_type ev;
      ev.cmd = cmd;
      ev.dom = dom;
      ev.has_type = has_type;
      ev.mtype = mtype;
      ev.yiaddr = yiaddr;
      ev.sid = sid;
      ev.lease = lease;
      return ev;
   endfunction

   function automatic dcl_pkg::rsp_type exp_rsp(input dcl_pkg::send_type send,
                                                input logic [8:0] frame,
                                                input logic arm, input logic [31:0] tmo,
                                                input dcl_pkg::verdict_type vd,
                                                input dcl_pkg::state_type st);
      dcl_pkg::rsp_type r;
      r = '0;
      r.send_kind = send;
      r.frame_bytes = frame;
      r.arm_timer = arm;
      r.timeout_us = tmo;
      r.verdict = vd;
      r.state_now = st;
      return r;
   endfunction

   task automatic add_row(input dhcp_evt_type ev, input bit typed,
                          input dcl_pkg::rsp_type want);
      stim_row_type row;
      row.ev = ev;
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endtask

   function automatic logic [31:0] random_lease();
      case ($urandom_range(3))
         0: return $urandom_range(16000);
         1: return $urandom_range(14400, 7200);
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // mostly the event the current state waits for, with random content
   function automatic dhcp_evt_type random_event();
      dhcp_evt_type ev;
      ev = mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b1, dcl_pkg::MT_ACK, $urandom, $urandom,
                    random_lease());
      if ($urandom_range(99) < 25) begin
         ev.cmd = 2'($urandom_range(3));
         ev.dom = 1'($urandom_range(1));
         ev.has_type = 1'($urandom_range(1));
         ev.mtype = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
      end else begin
         case (fsm_state)
            dcl_pkg::ST_INIT:
               ev.cmd = $urandom_range(1) ? dcl_pkg::CMD_START : dcl_pkg::CMD_TIMER;
            dcl_pkg::ST_SELECT: begin
               ev.mtype = dcl_pkg::MT_OFFER;
               if ($urandom_range(99) < 85) ev.cmd = dcl_pkg::CMD_REPLY;
            end
            dcl_pkg::ST_REQUEST: begin
               if ($urandom_range(99) < 85) ev.cmd = dcl_pkg::CMD_REPLY;
            end
            dcl_pkg::ST_BOUND: begin
               if ($urandom_range(99) < 10) ev.cmd = dcl_pkg::CMD_START;
            end
            default: begin
               if ($urandom_range(1)) ev.cmd = dcl_pkg::CMD_REPLY;
            end
         endcase
      end
      return ev;
   endfunction

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [31:0]      disc_vals[4];
      logic [31:0]      req_vals[4];
      dcl_pkg::rsp_type none;
      none = '0;
      disc_vals = '{32'h0, 32'hFFFF_FFFF, $urandom, dcl_pkg::TIMEOUT_RESET};
      req_vals  = '{32'h0, 32'hFFFF_FFFF, $urandom, dcl_pkg::TIMEOUT_RESET};

      // directed walk through every state with the reset timeouts
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_ACK, 32'h1, 32'h2, 32'h3),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_UNEXPECTED, dcl_pkg::ST_INIT));
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NONE, dcl_pkg::ST_INIT));
      add_row(mk_event(CMD_UNUSED, 1'b1, 1'b1, 8'hFF, '1, '1, '1),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NONE, dcl_pkg::ST_INIT));
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_DISCOVER, dcl_pkg::SMALL_FRAME, 1'b1,
                            dcl_pkg::TIMEOUT_RESET, dcl_pkg::VERDICT_NONE,
                            dcl_pkg::ST_SELECT));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b0, dcl_pkg::MT_OFFER, 32'h5, 32'h6,
                       32'h7),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NO_TYPE, dcl_pkg::ST_SELECT));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_ACK, 32'h5, 32'h6, 32'h7),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NOT_OFFER, dcl_pkg::ST_SELECT));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b0, 1'b1, dcl_pkg::MT_OFFER, '1, '1, '1),
              1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b1, dcl_pkg::MT_ACK, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_DISCOVER, dcl_pkg::SMALL_FRAME, 1'b1,
                            dcl_pkg::TIMEOUT_RESET, dcl_pkg::VERDICT_NONE,
                            dcl_pkg::ST_SELECT));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_OFFER, 32'd0, 32'd0,
                       32'd0), 1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_OFFER, 32'h9, 32'h9,
                       32'h9),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NOT_ACK, dcl_pkg::ST_REQUEST));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b0, 8'hFF, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NO_TYPE, dcl_pkg::ST_REQUEST));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b0, 1'b1, dcl_pkg::MT_ACK, '1, '1, '1),
              1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_ACK, 32'h1, 32'h1, 32'h1),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_UNEXPECTED, dcl_pkg::ST_BOUND));
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b0, 1'b1, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NONE, dcl_pkg::ST_BOUND));
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_OFFER, 32'd0, 32'd0,
                       32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NOT_ACK, dcl_pkg::ST_RENEW));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_ACK, 32'h0A00_0001,
                       32'h0A00_00FE, 32'd0), 1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, 8'h00, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_NONE, 9'd0, 1'b0, 32'd0,
                            dcl_pkg::VERDICT_NOT_ACK, dcl_pkg::ST_REBIND));
      // rebind runs out: address dropped, back to discovery
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_START, 1'b0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b1, exp_rsp(dcl_pkg::SEND_DISCOVER, dcl_pkg::SMALL_FRAME, 1'b1,
                            dcl_pkg::TIMEOUT_RESET, dcl_pkg::VERDICT_NONE,
                            dcl_pkg::ST_SELECT));
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_OFFER, 32'hC0A8_0064,
                       32'hC0A8_0001, 32'd0), 1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_REPLY, 1'b1, 1'b1, dcl_pkg::MT_ACK, 32'hC0A8_0064,
                       32'hC0A8_0001, 32'd7200), 1'b0, none);
      add_row(mk_event(dcl_pkg::CMD_TIMER, 1'b1, 1'b1, 8'd0, 32'd0, 32'd0, 32'd0),
              1'b0, none);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         feed_event(stim_rows[i].ev, stim_rows[i].typed, stim_rows[i].want);

      for (int p = 0; p < 4; p++) begin
         drain_results();
         write_csr(dcl_pkg::CSR_DISCOVER_TIMEOUT, disc_vals[p]);
         write_csr(dcl_pkg::CSR_REQUEST_TIMEOUT, req_vals[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            calm = (p == 1) && (n >= 100) && (n < 300);
            feed_event(random_event(), 1'b0, none);
         end
         calm = 1'b0;
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/dcl_pkg.sv
src/dcl_retry.sv
src/dcl_decide.sv
src/dhcp_client_lease_fsm.sv
dv/tb.sv
